// ===== rtl/core/tsnef_pkg.sv =====
// Package for the text stream number/escape filter: payload and queue types,
// character codes, register indexes and output position layout.
// No dependencies.
`timescale 1ns / 1ps

package tsnef_pkg;

  localparam int NUMBER_DIGITS = 6;
  localparam int BCD_W         = 4 * NUMBER_DIGITS;

  // Output positions of one command: digits (most significant first), tab,
  // dollar, caret, body byte.
  localparam int POS_TAB    = NUMBER_DIGITS;
  localparam int POS_DOLLAR = NUMBER_DIGITS + 1;
  localparam int POS_CARET  = NUMBER_DIGITS + 2;
  localparam int POS_BODY   = NUMBER_DIGITS + 3;
  localparam int MASK_W     = NUMBER_DIGITS + 4;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUMBER_MODE      = 3'd0,
    CFG_SQUEEZE_BLANK    = 3'd1,
    CFG_SHOW_ENDS        = 3'd2,
    CFG_SHOW_TABS        = 3'd3,
    CFG_SHOW_NONPRINTING = 3'd4
  } cfg_index_t;

  localparam logic [1:0] NUM_MODE_OFF      = 2'd0;
  localparam logic [1:0] NUM_MODE_ALL      = 2'd1;
  localparam logic [1:0] NUM_MODE_NONBLANK = 2'd2;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CTRL_LIMIT = 8'd32;
  localparam logic [7:0] ESC_OFFSET = 8'd64;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       file_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  // One classified input byte: which output positions it produces, the line
  // number to print and the body byte (raw or second escape character).
  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic [BCD_W-1:0]  bcd;
    logic [7:0]        body;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/core/text_stream_number_escape_filter.sv =====
// Text stream filter with line numbering, blank-line squeezing and escapes.
// Input transactions carry one byte and a file start flag; each produces
// zero to nine output transactions of one byte each, the final one marked
// by last. A squeezed blank line produces no output transaction at all.
// Options are written through the cfg port (index, data, write enable) and
// must only change while no transaction is in flight.
// The front end classifies one byte per cycle, unless the queue is full,
// into a command; a two-entry queue feeds the back end, which emits one
// output byte per cycle while out_stall is low. Plain bytes therefore flow
// at one per cycle; an input byte occupies the back end until all the bytes
// it yields (1 to 9, up to 9 when a line number precedes an escaped byte)
// are out, so the input is stalled while long expansions drain once the queue fills.
// With the back end idle, an accepted byte passes through the queue and
// the current command register to the output register.
// When out_stall is high the output register holds its transaction and the
// back end and queue fill up in turn before in_stall rises.
// Synchronous reset clears the options, the line number (back to one) and
// all queued transactions.
// Depends on tsnef_pkg, tsnef_front, tsnef_queue and tsnef_back.
`timescale 1ns / 1ps

module text_stream_number_escape_filter import tsnef_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  q_stat_t q_stat;
  logic    q_push, q_pop;
  cmd_t    q_cmd, q_head;

  tsnef_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  tsnef_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  tsnef_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/tsnef_front.sv =====
// Front end: configuration registers, line state and classification of each
// input byte into a command for the back end. Depends on tsnef_pkg.
`timescale 1ns / 1ps

module tsnef_front import tsnef_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  q_stat_t               q_stat,
  output logic                  q_push,
  output cmd_t                  q_cmd
);

  logic [1:0]       number_mode_r;
  logic             squeeze_r, show_ends_r, show_tabs_r, show_np_r;
  logic             prev_nl_r, prev_nl_nxt;
  logic [1:0]       blank_run_r, blank_run_nxt;
  logic [BCD_W-1:0] bcd_r, bcd_nxt;

  logic             accept;
  logic             pn;
  logic [1:0]       br;
  logic [BCD_W-1:0] bcd_cur;
  logic [7:0]       c;
  logic             is_nl, sq_sup, num_en, dollar_en, tab_esc, np_esc, body_en;
  logic [7:0]       body;

  function automatic logic [BCD_W-1:0] bcd_inc(input logic [BCD_W-1:0] v);
    logic [BCD_W-1:0] r;
    logic             carry;
    logic             all9;
    r     = v;
    carry = 1'b1;
    all9  = 1'b1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (v[4*i +: 4] != 4'd9) all9 = 1'b0;
    end
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (carry) begin
        if (r[4*i +: 4] == 4'd9) begin
          r[4*i +: 4] = 4'd0;
        end else begin
          r[4*i +: 4] = 4'(r[4*i +: 4] + 4'd1);
          carry       = 1'b0;
        end
      end
    end
    return all9 ? v : r;
  endfunction

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;

  always_comb begin
    c       = in_data.in_byte;
    pn      = in_data.file_start ? 1'b1 : prev_nl_r;
    br      = in_data.file_start ? 2'd0 : blank_run_r;
    bcd_cur = in_data.file_start ? BCD_W'(1) : bcd_r;
    is_nl   = (c == CH_NL);

    sq_sup        = 1'b0;
    blank_run_nxt = br;
    if (squeeze_r) begin
      if (pn && is_nl) begin
        sq_sup = (br != 2'd0);
        if (br < 2'd2) blank_run_nxt = 2'(br + 2'd1);
      end else begin
        blank_run_nxt = 2'd0;
      end
    end

    case (number_mode_r)
      NUM_MODE_OFF:      num_en = 1'b0;
      NUM_MODE_ALL:      num_en = (blank_run_nxt <= 2'd1) && pn;
      NUM_MODE_NONBLANK: num_en = pn && !is_nl;
      // The unused fourth code numbers non-blank lines as well.
      default:           num_en = pn && !is_nl;
    endcase

    dollar_en = show_ends_r && (blank_run_nxt <= 2'd1) && is_nl;
    tab_esc   = show_tabs_r && (c == CH_TAB);
    np_esc    = show_np_r &&
                (((c != CH_TAB) && !is_nl && (c < CTRL_LIMIT)) || (c == CH_DEL));
    body_en   = tab_esc || np_esc || !sq_sup;

    if (tab_esc)         body = CH_I;
    else if (c == CH_DEL && np_esc) body = CH_QMARK;
    else if (np_esc)     body = 8'(c + ESC_OFFSET);
    else                 body = c;

    q_cmd.mask                          = '0;
    q_cmd.mask[NUMBER_DIGITS-1:0]       = {NUMBER_DIGITS{num_en}};
    q_cmd.mask[POS_TAB]                 = num_en;
    q_cmd.mask[POS_DOLLAR]              = dollar_en;
    q_cmd.mask[POS_CARET]               = tab_esc || np_esc;
    q_cmd.mask[POS_BODY]                = body_en;
    q_cmd.bcd                           = bcd_cur;
    q_cmd.body                          = body;

    bcd_nxt     = num_en ? bcd_inc(bcd_cur) : bcd_cur;
    prev_nl_nxt = is_nl;
  end

  // A squeezed newline with nothing to print produces no command at all.
  assign q_push = accept && (q_cmd.mask != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_nl_r   <= 1'b1;
      blank_run_r <= 2'd0;
      bcd_r       <= BCD_W'(1);
    end else if (accept) begin
      prev_nl_r   <= prev_nl_nxt;
      blank_run_r <= blank_run_nxt;
      bcd_r       <= bcd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_mode_r <= NUM_MODE_OFF;
      squeeze_r     <= 1'b0;
      show_ends_r   <= 1'b0;
      show_tabs_r   <= 1'b0;
      show_np_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_NUMBER_MODE:      number_mode_r <= cfg_wdata[1:0];
        CFG_SQUEEZE_BLANK:    squeeze_r     <= cfg_wdata[0];
        CFG_SHOW_ENDS:        show_ends_r   <= cfg_wdata[0];
        CFG_SHOW_TABS:        show_tabs_r   <= cfg_wdata[0];
        CFG_SHOW_NONPRINTING: show_np_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/tsnef_queue.sv =====
// Short command queue between the front and back ends.
// Depends on tsnef_pkg.
`timescale 1ns / 1ps

module tsnef_queue import tsnef_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    head,
  output q_stat_t stat
);

  cmd_t                mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]   count_r, count_nxt;

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);

  always_comb begin
    count_nxt = count_r;
    if (push && !pop)      count_nxt = (QUEUE_AW+1)'(count_r + 1'b1);
    else if (!push && pop) count_nxt = (QUEUE_AW+1)'(count_r - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= QUEUE_AW'(wr_ptr_r + 1'b1);
      if (pop)  rd_ptr_r <= QUEUE_AW'(rd_ptr_r + 1'b1);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

endmodule

// ===== rtl/core/tsnef_back.sv =====
// Back end: expands the head command into output bytes, one per cycle while
// out_stall is low, and holds them in the output register. Depends on tsnef_pkg.
`timescale 1ns / 1ps

module tsnef_back import tsnef_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      head,
  input  q_stat_t   q_stat,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic              cur_valid_r;
  logic [MASK_W-1:0] cur_mask_r;
  logic [BCD_W-1:0]  cur_bcd_r;
  logic [7:0]        cur_body_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic              out_free, emit, is_last;
  logic [MASK_W-1:0] low_bit, rem_mask;
  logic [7:0]        pos_byte [MASK_W];
  logic [7:0]        sel_byte;
  logic              seen;
  logic [3:0]        digit;

  assign out_free = !out_valid_r || !out_stall;
  assign emit     = cur_valid_r && out_free;
  assign low_bit  = cur_mask_r & MASK_W'(~cur_mask_r + 1'b1);
  assign rem_mask = cur_mask_r & ~low_bit;
  assign is_last  = (rem_mask == '0);
  assign q_pop    = !q_stat.empty && (!cur_valid_r || (emit && is_last));

  always_comb begin
    // Digits go out most significant first; leading zeros become spaces,
    // but the units digit is always printed.
    seen = 1'b0;
    for (int k = 0; k < NUMBER_DIGITS; k++) begin
      digit = cur_bcd_r[4*(NUMBER_DIGITS-1-k) +: 4];
      if (digit != 4'd0 || k == NUMBER_DIGITS - 1) seen = 1'b1;
      pos_byte[k] = seen ? (CH_ZERO | {4'd0, digit}) : CH_SPACE;
    end
    pos_byte[POS_TAB]    = CH_TAB;
    pos_byte[POS_DOLLAR] = CH_DOLLAR;
    pos_byte[POS_CARET]  = CH_CARET;
    pos_byte[POS_BODY]   = cur_body_r;

    sel_byte = '0;
    for (int k = 0; k < MASK_W; k++) begin
      if (low_bit[k]) sel_byte = sel_byte | pos_byte[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      cur_mask_r  <= '0;
    end else if (q_pop) begin
      cur_valid_r <= 1'b1;
      cur_mask_r  <= head.mask;
    end else if (emit) begin
      cur_valid_r <= !is_last;
      cur_mask_r  <= rem_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_bcd_r  <= head.bcd;
      cur_body_r <= head.body;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r.out_byte <= sel_byte;
      out_data_r.last     <= is_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
